// ===== hdl/vlpd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the video line payload decoder: constants, sequencer and
// phase types, and the command struct for the bit-serial CRC unit.
package vlpd_pkg;

   localparam logic [15:0] WORD_BIAS  = 16'h4040;
   localparam logic [15:0] LOW_KEEP   = 16'h0101;
   localparam logic [15:0] LOW_SHIFT  = 16'hfefe;
   localparam logic [13:0] MAX_WORDS  = 14'd627;
   localparam logic [13:0] MIN_WORDS  = 14'd2;
   localparam logic [31:0] CRC_POLY   = 32'h04c11db7;
   localparam logic [31:0] CRC_PRESET = 32'hffffffff;
   localparam logic [30:0] LCG_MUL    = 31'd1103515245;
   localparam logic [30:0] LCG_ADD    = 31'd12345;
   localparam logic [2:0]  GROUP_LEN  = 3'd7;
   localparam logic [2:0]  CRC_BYTES  = 3'd4;
   localparam logic [4:0]  BITS_WORD  = 5'd16;
   localparam logic [4:0]  BITS_BYTE  = 5'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_LCG,
      ST_BYTE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COUNT,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic        go;
      logic        init;
      logic [15:0] data;
      logic [4:0]  nbits;
   } crc_cmd_type;

endpackage

// ===== hdl/vlpd_ifs.sv =====
`timescale 1ns / 1ps
// Handshake channels of the video line payload decoder: captured words in,
// decoded bytes and line status out. No dependencies.
interface vlpd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] capture_word;
   logic        line_start;

   modport source (output valid, output capture_word, output line_start, input ready);
   modport sink (input valid, input capture_word, input line_start, output ready);
endinterface

interface vlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       byte_valid;
   logic       line_done;
   logic       line_ok;
   logic [7:0] line_number;
   logic       last;

   modport source (output valid, output byte_out, output byte_valid, output line_done,
                   output line_ok, output line_number, output last, input ready);
   modport sink (input valid, input byte_out, input byte_valid, input line_done,
                 input line_ok, input line_number, input last, output ready);
endinterface

// ===== hdl/vlpd_crc_unit.sv =====
`timescale 1ns / 1ps
// Bit-serial CRC-32/MPEG-2 engine, one message bit per cycle, MSB first.
// Depends on vlpd_pkg.
module vlpd_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  vlpd_pkg::crc_cmd_type cmd,
   output logic [31:0]           crc,
   output logic                  busy
);
   import vlpd_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [15:0] data_ff, data_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        fb;

   always_comb begin
      crc_in  = crc_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      fb      = crc_ff[31] ^ data_ff[15];
      if (cmd.go) begin
         // load the message, left aligned
         if (cmd.init) begin
            crc_in = CRC_PRESET;
         end
         data_in = cmd.data;
         cnt_in  = cmd.nbits;
      end else if (cnt_ff != 5'd0) begin
         crc_in  = {crc_ff[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
         data_in = {data_ff[14:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_PRESET;
         cnt_ff <= 5'd0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
      data_ff <= data_in;
   end

   assign crc  = crc_ff;
   assign busy = (cnt_ff != 5'd0);

   // a command is only issued while the engine is idle
   assert property (@(posedge clock) disable iff (reset) cmd.go |-> !busy)
      else $error("crc command while busy");
   // a byte command loads the byte bit count as its step count
   assert property (@(posedge clock) disable iff (reset)
      (cmd.go && cmd.nbits == BITS_BYTE) |=> (cnt_ff == BITS_BYTE))
      else $error("crc byte count not loaded");
   assert property (@(posedge clock) disable iff (reset)
      (busy && !cmd.go) |=> (cnt_ff == $past(cnt_ff) - 5'd1))
      else $error("crc step count did not advance");

endmodule

// ===== hdl/video_line_payload_decoder_top.sv =====
`timescale 1ns / 1ps
// Video line payload decoder, top level. Depends on vlpd_pkg, vlpd_ifs and
// vlpd_crc_unit.
// A prefix word occupies the block for its serial CRC pass; a header word, or a
// count word in range, is handled in the idle state; a data word, when rsp is
// taken at once, runs per byte one scrambler multiply and one byte stage, and for
// bytes past the CRC field a pass of the bit-serial CRC unit, which sets the rate. One word is in work at a time.
// Reset: synchronous, active high; waits for a prefix word, CRC all ones.
module video_line_payload_decoder_top (
   input logic        clock,
   input logic        reset,
   vlpd_req_if.sink   req_chan,
   vlpd_rsp_if.source rsp_chan
);
   import vlpd_pkg::*;

   // sequencer
   state_type   state_ff, state_in;

   // line state
   phase_type   phase_ff, phase_in;
   logic [15:0] low_ff, low_in;          // header bits not yet used
   logic [2:0]  grp_ff, grp_in;          // data words left in the group
   logic [13:0] words_ff, words_in;      // data words left in the line
   logic [30:0] scr_ff, scr_in;          // scrambler generator
   logic [31:0] recv_ff, recv_in;        // CRC carried in bytes 0..3
   logic [2:0]  pos_ff, pos_in;          // bytes seen, held at four
   logic [7:0]  lidx_ff, lidx_in;        // line number

   // word in work
   logic [15:0] word_ff, word_in;        // rebuilt data word
   logic        sel_ff, sel_in;          // 0 high byte, 1 low byte
   logic        pend_ff, pend_in;        // a result waits behind the CRC pass

   // result register
   logic [7:0]  ob_ff, ob_in;
   logic        obv_ff, obv_in;
   logic        odone_ff, odone_in;
   logic        ook_ff, ook_in;
   logic        olast_ff, olast_in;

   crc_cmd_type crc_cmd;
   logic [31:0] crc_val;
   logic        crc_busy;

   logic        req_fire, rsp_fire;
   logic [15:0] cur;
   logic [13:0] cnt;
   logic [30:0] lcg_next;
   logic [7:0]  raw_byte, dec_byte;

   vlpd_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .crc   (crc_val),
      .busy  (crc_busy)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // bias removal, count assembly, scrambler step and byte descramble
   assign cur      = req_chan.capture_word - WORD_BIAS;
   assign cnt      = {cur[14:8], cur[6:0]};
   assign lcg_next = (scr_ff * LCG_MUL) + LCG_ADD;
   assign raw_byte = sel_ff ? word_ff[7:0] : word_ff[15:8];
   assign dec_byte = raw_byte ^ scr_ff[15:8];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.line_start) begin
                  state_in = ST_CRC;
               end else if (phase_ff == PH_COUNT) begin
                  if (cnt > MAX_WORDS || cnt < MIN_WORDS) begin
                     state_in = ST_OUT;
                  end
               end else if (phase_ff == PH_DATA && grp_ff != 3'd0) begin
                  state_in = ST_LCG;
               end
            end
         end
         ST_CRC: begin
            if (!crc_busy) begin
               state_in = pend_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_LCG: begin
            state_in = ST_BYTE;
         end
         ST_BYTE: begin
            state_in = (pos_ff < CRC_BYTES) ? ST_OUT : ST_CRC;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (odone_ff) begin
                  state_in = ST_IDLE;
               end else if (!sel_ff) begin
                  state_in = ST_LCG;
               end else if (words_ff == 14'd0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in = phase_ff;
      low_in   = low_ff;
      grp_in   = grp_ff;
      words_in = words_ff;
      scr_in   = scr_ff;
      recv_in  = recv_ff;
      pos_in   = pos_ff;
      lidx_in  = lidx_ff;
      word_in  = word_ff;
      sel_in   = sel_ff;
      pend_in  = pend_ff;
      ob_in    = ob_ff;
      obv_in   = obv_ff;
      odone_in = odone_ff;
      ook_in   = ook_ff;
      olast_in = olast_ff;
      crc_cmd  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.line_start) begin
                  // new prefix: seed everything, drop any open line
                  lidx_in       = req_chan.capture_word[15:8];
                  scr_in        = {15'd0, req_chan.capture_word};
                  recv_in       = 32'd0;
                  pos_in        = 3'd0;
                  low_in        = 16'd0;
                  grp_in        = 3'd0;
                  words_in      = 14'd0;
                  phase_in      = PH_COUNT;
                  pend_in       = 1'b0;
                  crc_cmd.go    = 1'b1;
                  crc_cmd.init  = 1'b1;
                  crc_cmd.data  = req_chan.capture_word;
                  crc_cmd.nbits = BITS_WORD;
               end else begin
                  case (phase_ff)
                     PH_COUNT: begin
                        if (cnt > MAX_WORDS || cnt < MIN_WORDS) begin
                           // bad length: close the line as failed
                           phase_in = PH_IDLE;
                           ob_in    = 8'd0;
                           obv_in   = 1'b0;
                           odone_in = 1'b1;
                           ook_in   = 1'b0;
                           olast_in = 1'b1;
                        end else begin
                           words_in = cnt;
                           grp_in   = 3'd0;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        if (grp_ff == 3'd0) begin
                           low_in = cur;
                           grp_in = GROUP_LEN;
                        end else begin
                           word_in  = {cur[14:0], 1'b0} | (low_ff & LOW_KEEP);
                           low_in   = (low_ff & LOW_SHIFT) >> 1;
                           grp_in   = grp_ff - 3'd1;
                           words_in = words_ff - 14'd1;
                           sel_in   = 1'b0;
                        end
                     end
                     default: begin
                        // no line open: drop the word
                     end
                  endcase
               end
            end
         end
         ST_CRC: begin
            if (!crc_busy) begin
               pend_in = 1'b0;
            end
         end
         ST_LCG: begin
            scr_in = lcg_next;
         end
         ST_BYTE: begin
            ob_in    = dec_byte;
            obv_in   = 1'b1;
            odone_in = 1'b0;
            ook_in   = 1'b0;
            // the low byte ends the word's results unless the status item follows
            olast_in = sel_ff && (words_ff != 14'd0);
            if (pos_ff < CRC_BYTES) begin
               // first four bytes carry the expected CRC
               recv_in = {recv_ff[23:0], dec_byte};
               pos_in  = pos_ff + 3'd1;
            end else begin
               pend_in       = 1'b1;
               crc_cmd.go    = 1'b1;
               crc_cmd.init  = 1'b0;
               crc_cmd.data  = {dec_byte, 8'd0};
               crc_cmd.nbits = BITS_BYTE;
            end
         end
         ST_OUT: begin
            if (rsp_fire && !odone_ff) begin
               if (!sel_ff) begin
                  sel_in = 1'b1;
               end else if (words_ff == 14'd0) begin
                  // last data word: follow with the status item
                  phase_in = PH_IDLE;
                  ob_in    = 8'd0;
                  obv_in   = 1'b0;
                  odone_in = 1'b1;
                  ook_in   = (crc_val == recv_ff);
                  olast_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         low_ff   <= 16'd0;
         grp_ff   <= 3'd0;
         words_ff <= 14'd0;
         scr_ff   <= 31'd0;
         recv_ff  <= 32'd0;
         pos_ff   <= 3'd0;
         lidx_ff  <= 8'd0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         low_ff   <= low_in;
         grp_ff   <= grp_in;
         words_ff <= words_in;
         scr_ff   <= scr_in;
         recv_ff  <= recv_in;
         pos_ff   <= pos_in;
         lidx_ff  <= lidx_in;
         pend_ff  <= pend_in;
      end
      word_ff  <= word_in;
      sel_ff   <= sel_in;
      ob_ff    <= ob_in;
      obv_ff   <= obv_in;
      odone_ff <= odone_in;
      ook_ff   <= ook_in;
      olast_ff <= olast_in;
   end

   assign rsp_chan.byte_out    = ob_ff;
   assign rsp_chan.byte_valid  = obv_ff;
   assign rsp_chan.line_done   = odone_ff;
   assign rsp_chan.line_ok     = ook_ff;
   assign rsp_chan.line_number = lidx_ff;
   assign rsp_chan.last        = olast_ff;

   // no new word is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_chan.valid |-> !req_chan.ready)
      else $error("input accepted while result pending");
   // the status item always closes the word's results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.line_done) |-> (rsp_chan.last && !rsp_chan.byte_valid))
      else $error("status item not marked last");
   // a byte item never carries status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.byte_valid) |-> (!rsp_chan.line_done && !rsp_chan.line_ok))
      else $error("byte item carries status");
   // every scrambler step is followed by a byte stage
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_LCG) |=> (state_ff == ST_BYTE))
      else $error("scrambler step not followed by byte stage");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for video_line_payload_decoder_top: builds scrambled video lines with good and
// broken CRCs, predicts every decoded byte and line status and checks them in order.
// Depends on vlpd_pkg (phase enum) and vlpd_ifs (req/rsp channels).
module testbench;
   import vlpd_pkg::*;

   localparam logic [15:0] WORD_OFFSET    = 16'h4040;
   localparam logic [15:0] KEEP_MASK      = 16'h0101;
   localparam logic [15:0] SHIFT_MASK     = 16'hfefe;
   localparam logic [31:0] CRC_GEN        = 32'h04c11db7;
   localparam logic [31:0] CRC_SEED       = 32'hffffffff;
   localparam logic [30:0] LCG_A          = 31'd1103515245;
   localparam logic [30:0] LCG_C          = 31'd12345;
   localparam int          LINE_MAX_WORDS = 627;
   localparam int          MIN_COUNT      = 2;
   localparam int          GROUP_SIZE     = 7;
   localparam int          CRC_LEN        = 4;
   localparam int          MAX_GAP        = 13;
   localparam int          RANDOM_WORDS   = 370;
   localparam int          LONG_LINE_CUT  = 16;
   localparam int          DRAIN_CYCLES   = 80;
   localparam int          CYCLE_LIMIT    = 600000;
   localparam int          PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       line_done;
      logic       line_ok;
      logic [7:0] line_number;
      logic       last;
   } line_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vlpd_req_if req_bus ();
   vlpd_rsp_if rsp_bus ();

   video_line_payload_decoder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // Decoder state as seen from outside; values match the block after reset.
   phase_type   line_phase  = PH_IDLE;
   logic [15:0] header_bits = '0;
   logic [2:0]  group_left  = '0;
   logic [13:0] data_left   = '0;
   logic [30:0] scrambler   = '0;
   logic [31:0] crc_calc    = CRC_SEED;
   logic [31:0] crc_sent    = '0;
   logic [10:0] bytes_seen  = '0;
   logic [7:0]  line_id     = '0;

   line_item_type expected_decodes[$];
   line_item_type got_item;
   line_item_type want_item;

   int          error_count = 0;
   int          cycle_count = 0;
   int          words_sent  = 0;
   // When set, both sides run back to back with no idle cycles.
   bit          no_idle     = 1'b0;

   // -----------------------------------------------------------------------------------
   // Prediction
   // -----------------------------------------------------------------------------------
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      int          i;
      c = crc ^ {data, 24'h0};
      for (i = 0; i < 8; i++)
         c = c[31] ? ((c << 1) ^ CRC_GEN) : (c << 1);
      return c;
   endfunction

   function automatic logic [30:0] lcg_next(input logic [30:0] x);
      return LCG_A * x + LCG_C;
   endfunction

   // Advance the scrambler, unscramble one byte and fold it into the CRC fields.
   function automatic logic [7:0] descramble_byte(input logic [7:0] raw);
      logic [7:0] b;
      scrambler = lcg_next(scrambler);
      b = raw ^ scrambler[15:8];
      if (bytes_seen < 11'(CRC_LEN)) begin
         crc_sent   = {crc_sent[23:0], b};
         bytes_seen = bytes_seen + 11'd1;
      end else begin
         crc_calc = crc_step(crc_calc, b);
      end
      return b;
   endfunction

   function automatic void push_decode(input logic [7:0] b, input logic is_byte,
                                       input logic done, input logic ok, input logic fin);
      line_item_type r;
      r.byte_out    = b;
      r.byte_valid  = is_byte;
      r.line_done   = done;
      r.line_ok     = ok;
      r.line_number = line_id;
      r.last        = fin;
      expected_decodes.push_back(r);
   endfunction

   // Work out what one accepted captured word produces.
   function automatic void decode_capture_word(input logic [15:0] word, input logic start);
      logic [15:0] cur;
      logic [15:0] v;
      logic [13:0] n;
      logic [7:0]  hi;
      logic [7:0]  lo;
      cur = word - WORD_OFFSET;
      if (start) begin
         // A line start always wins, even in mid-line: drop the old line silently.
         line_id     = word[15:8];
         scrambler   = {15'd0, word};
         crc_calc    = crc_step(crc_step(CRC_SEED, word[15:8]), word[7:0]);
         crc_sent    = '0;
         bytes_seen  = '0;
         header_bits = '0;
         group_left  = '0;
         data_left   = '0;
         line_phase  = PH_COUNT;
      end else if (line_phase == PH_COUNT) begin
         n = {cur[14:8], cur[6:0]};
         if (n > LINE_MAX_WORDS || n < MIN_COUNT) begin
            // Bad length closes the line at once with a failing status.
            line_phase = PH_IDLE;
            push_decode(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
         end else begin
            data_left  = n;
            group_left = '0;
            line_phase = PH_DATA;
         end
      end else if (line_phase == PH_DATA) begin
         if (group_left == 3'd0) begin
            header_bits = cur;
            group_left  = 3'(GROUP_SIZE);
         end else begin
            v           = {cur[14:0], 1'b0} | (header_bits & KEEP_MASK);
            header_bits = (header_bits & SHIFT_MASK) >> 1;
            group_left  = group_left - 3'd1;
            data_left   = data_left - 14'd1;
            hi = descramble_byte(v[15:8]);
            lo = descramble_byte(v[7:0]);
            push_decode(hi, 1'b1, 1'b0, 1'b0, 1'b0);
            // The low byte is last unless the line closes with a status item.
            push_decode(lo, 1'b1, 1'b0, 1'b0, data_left != 14'd0);
            if (data_left == 14'd0) begin
               push_decode(8'h00, 1'b0, 1'b1, crc_calc == crc_sent, 1'b1);
               line_phase = PH_IDLE;
            end
         end
      end
      // Words without a line start while idle are ignored.
   endfunction

   // -----------------------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------------------
   // Send one item on req. Valid stays high across back-to-back items, so drop it only
   // when a gap is drawn.
   task automatic send_word(input logic [15:0] word, input logic start);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.capture_word <= word;
      req_bus.line_start   <= start;
      do @(posedge clock); while (!req_bus.ready);
      decode_capture_word(word, start);
      words_sent++;
   endtask

   // Count word for n data words; spare carries the two ignored bits (7 and 15).
   function automatic logic [15:0] count_word(input logic [13:0] n, input logic [1:0] spare);
      return {spare[1], n[13:7], spare[0], n[6:0]} + WORD_OFFSET;
   endfunction

   // Build and send one line of count data words. The first four payload bytes carry the
   // CRC; corrupt flips one bit so the check fails. A cut_at of zero or more abandons the
   // line after that many words past the count word.
   task automatic send_line(input logic [15:0] prefix, input int count, input bit corrupt,
                            input int cut_at);
      logic [7:0]  plain [0:2*LINE_MAX_WORDS-1];
      logic [31:0] crc;
      logic [30:0] x;
      logic [15:0] v;
      logic [15:0] hdr;
      logic [15:0] cur;
      int          n_bytes;
      int          k;
      int          w;
      int          g;
      int          grp;
      int          posn;
      n_bytes = 2 * count;
      for (k = CRC_LEN; k < n_bytes; k++)
         plain[k] = 8'($urandom);
      crc = crc_step(crc_step(CRC_SEED, prefix[15:8]), prefix[7:0]);
      for (k = CRC_LEN; k < n_bytes; k++)
         crc = crc_step(crc, plain[k]);
      for (k = 0; k < CRC_LEN; k++)
         plain[k] = crc[31 - 8*k -: 8];
      if (corrupt)
         plain[$urandom_range(0, n_bytes - 1)] ^= 8'h01 << $urandom_range(0, 7);
      x = {15'd0, prefix};
      for (k = 0; k < n_bytes; k++) begin
         x = lcg_next(x);
         plain[k] ^= x[15:8];
      end

      send_word(prefix, 1'b1);
      send_word(count_word(14'(count), 2'($urandom)), 1'b0);
      posn = 0;
      w = 0;
      while (w < count) begin
         grp = (count - w < GROUP_SIZE) ? count - w : GROUP_SIZE;
         // Low bits of each data word ride in the header; bit 8 may also come from the
         // data word itself, since the two are ORed.
         hdr = 16'($urandom);
         for (g = 0; g < grp; g++) begin
            hdr[g]     = plain[2*(w+g)+1][0];
            hdr[8 + g] = plain[2*(w+g)][0] & 1'($urandom);
         end
         if (posn == cut_at)
            return;
         send_word(hdr + WORD_OFFSET, 1'b0);
         posn++;
         for (g = 0; g < grp; g++) begin
            v   = {plain[2*(w+g)], plain[2*(w+g)+1]};
            cur = {1'($urandom), v[15:1]};
            if (hdr[8 + g])
               cur[7] = 1'($urandom);
            if (posn == cut_at)
               return;
            send_word(cur + WORD_OFFSET, 1'b0);
            posn++;
         end
         w += grp;
      end
   endtask

   // -----------------------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------------------
   task automatic test_ignored_words();
      // No line open yet: this word must vanish.
      send_word(16'($urandom), 1'b0);
   endtask

   task automatic test_bad_counts();
      // One past the limit, then a count too short to hold the CRC.
      send_word(16'h1234, 1'b1);
      send_word(count_word(14'(LINE_MAX_WORDS + 1), 2'b00), 1'b0);
      send_word(16'h00ff, 1'b1);
      send_word(count_word(14'd1, 2'b11), 1'b0);
   endtask

   task automatic test_short_lines();
      send_line(16'h0000, MIN_COUNT, 1'b0, -1);
      send_line(16'hffff, MIN_COUNT, 1'b1, -1);
   endtask

   task automatic test_restart_mid_line();
      // Abandon one line after its first data word, another right after its count.
      send_line(16'($urandom), 5, 1'b0, 2);
      send_word(16'($urandom), 1'b1);
      send_word(count_word(14'd9, 2'b10), 1'b0);
      // Raw extremes as header and data words of a two-word line.
      send_word(16'h8001, 1'b1);
      send_word(count_word(14'(MIN_COUNT), 2'b01), 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'hffff, 1'b0);
      send_word(16'h0000, 1'b0);
   endtask

   task automatic test_full_length_line();
      // Open a line of the largest legal count and run its first groups.
      send_line(16'($urandom), LINE_MAX_WORDS, 1'b0, LONG_LINE_CUT);
   endtask

   task automatic test_random_lines();
      int pick;
      int count;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         count   = ($urandom_range(0, 7) == 0) ? $urandom_range(MIN_COUNT, 120)
                                               : $urandom_range(MIN_COUNT, 20);
         if (pick < 5) begin
            // Stray word: ignored when idle, eaten as data after an abandoned line.
            send_word(16'($urandom), 1'b0);
         end else if (pick < 15) begin
            // Prefix with an arbitrary count word.
            send_word(16'($urandom), 1'b1);
            send_word(16'($urandom), 1'b0);
         end else if (pick < 25) begin
            send_line(16'($urandom), count, 1'b0, $urandom_range(0, count));
         end else if (pick < 40) begin
            send_line(16'($urandom), count, 1'b1, -1);
         end else begin
            send_line(16'($urandom), count, 1'b0, -1);
         end
      end
      no_idle = 1'b0;
   endtask

   // -----------------------------------------------------------------------------------
   // Result side: pacing and checking
   // -----------------------------------------------------------------------------------
   // Draw a stall for each item; hold ready high across items when no stall is drawn.
   initial begin : rsp_pacing
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_item = {rsp_bus.byte_out, rsp_bus.byte_valid, rsp_bus.line_done,
                     rsp_bus.line_ok, rsp_bus.line_number, rsp_bus.last};
         if (expected_decodes.size() == 0) begin
            report_mismatch("item with nothing pending", got_item.byte_out, 8'h00);
         end else begin
            want_item = expected_decodes.pop_front();
            if (got_item.byte_out !== want_item.byte_out)
               report_mismatch("byte_out", got_item.byte_out, want_item.byte_out);
            if (got_item.byte_valid !== want_item.byte_valid)
               report_mismatch("byte_valid", got_item.byte_valid, want_item.byte_valid);
            if (got_item.line_done !== want_item.line_done)
               report_mismatch("line_done", got_item.line_done, want_item.line_done);
            if (got_item.line_ok !== want_item.line_ok)
               report_mismatch("line_ok", got_item.line_ok, want_item.line_ok);
            if (got_item.line_number !== want_item.line_number)
               report_mismatch("line_number", got_item.line_number, want_item.line_number);
            if (got_item.last !== want_item.last)
               report_mismatch("last", got_item.last, want_item.last);
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -----------------------------------------------------------------------------------
   // Sequence
   // -----------------------------------------------------------------------------------
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.capture_word = 16'h0000;
      req_bus.line_start   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_ignored_words();
      test_bad_counts();
      test_short_lines();
      test_restart_mid_line();
      test_full_length_line();
      test_random_lines();

      req_bus.valid <= 1'b0;
      // Wait out every predicted item, then give stray results time to show up.
      while (expected_decodes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
